[src/fmd_pkg.sv]
`default_nettype none
package fmd_pkg;

	// Stream and length widths.
	localparam int BYTE_W = 8;
	localparam int LEN_W = 20;
	localparam int ACC_W = LEN_W + 4;
	localparam int HEADER_LENGTH = 12;
	localparam int POS_W = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] SOH_BYTE = 8'h01;
	localparam logic [BYTE_W-1:0] ZERO_CHAR = 8'h30;
	localparam logic [BYTE_W-1:0] NINE_CHAR = 8'h39;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 20'd65535;

	// Kind codes carried on the output tuser.
	typedef enum logic [1:0] {
		KIND_DISCARD = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_END     = 2'd2,
		KIND_ABORT   = 2'd3
	} kind_t;

	// Classified byte as it travels from the front to the back.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_soh;
		logic              is_digit;
		logic [3:0]        digit;
	} class_t;

	// Expected header byte at a given position; positions past the
	// standard twelve bytes expect zero.
	function automatic logic [BYTE_W-1:0] header_byte(input logic [POS_W-1:0] pos);
		logic [BYTE_W-1:0] b;
		case (pos)
			4'd0:    b = 8'h38;
			4'd1:    b = 8'h3D;
			4'd2:    b = 8'h46;
			4'd3:    b = 8'h49;
			4'd4:    b = 8'h58;
			4'd5:    b = 8'h2E;
			4'd6:    b = 8'h34;
			4'd7:    b = 8'h2E;
			4'd8:    b = 8'h32;
			4'd9:    b = SOH_BYTE;
			4'd10:   b = 8'h39;
			4'd11:   b = 8'h3D;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

[src/fmd_front.sv]
`default_nettype none
module fmd_front
	import fmd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	output logic             push_valid,
	input  wire logic        push_ready,
	output class_t           push_item
);

	logic   valid_s1;
	class_t item_s1;
	class_t item_c;

	// Classify the incoming byte: SOH, decimal digit and its value.
	// ASCII digits carry their value in the low nibble.
	always_comb begin
		item_c.data = s_axis_tdata;
		item_c.is_soh = (s_axis_tdata == SOH_BYTE);
		item_c.is_digit = (s_axis_tdata >= ZERO_CHAR) && (s_axis_tdata <= NINE_CHAR);
		item_c.digit = s_axis_tdata[3:0];
	end

	assign s_axis_tready = !valid_s1 || push_ready;

	// Stage register; it refills whenever the queue takes the held beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_c;
		end
	end

	assign push_valid = valid_s1;
	assign push_item = item_s1;

endmodule
`default_nettype wire

[src/fmd_queue.sv]
`default_nettype none
module fmd_queue
	import fmd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire class_t push_item,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output class_t      pop_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	class_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

[src/fmd_back.sv]
`default_nettype none
module fmd_back
	import fmd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [LEN_W-1:0]  cfg_wr_data,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire class_t            pop_item,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [31:0]            m_axis_tdata,
	output logic [1:0]             m_axis_tuser
);

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_LENGTH = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_RESYNC = 4'b1000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [LEN_W-1:0]  acc_q, acc_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic              seen_q, seen_d;
	logic [LEN_W-1:0]  max_len_q;

	kind_t             kind_c;
	logic [LEN_W-1:0]  blen_c;
	logic [ACC_W-1:0]  next_len;
	logic [POS_W:0]    pos_inc;
	logic [LEN_W-1:0]  rem_dec;
	logic              take;

	kind_t             kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic [LEN_W-1:0]  blen_q;

	assign pop_ready = !m_axis_tvalid || m_axis_tready;
	assign take = pop_valid && pop_ready;

	// Shared arithmetic for the header, length and body phases.
	always_comb begin
		next_len = ({1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}) + ACC_W'(pop_item.digit);
		pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
		rem_dec = rem_q - LEN_W'(1);
	end

	// Framing state machine: one byte per cycle while a byte is waiting and the output is not stalled.
	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		acc_d = acc_q;
		rem_d = rem_q;
		seen_d = seen_q;
		kind_c = KIND_DISCARD;
		blen_c = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (pop_item.data == header_byte(pos_q)) begin
					kind_c = KIND_FRAME;
					if (pos_inc >= (POS_W+1)'(HEADER_LENGTH)) begin
						phase_d = PH_LENGTH;
						pos_d = '0;
					end else begin
						pos_d = pos_inc[POS_W-1:0];
					end
				end else begin
					kind_c = KIND_ABORT;
					phase_d = PH_RESYNC;
					pos_d = '0;
				end
			end
			PH_LENGTH: begin
				if (pop_item.is_digit) begin
					if (next_len > ACC_W'(max_len_q)) begin
						kind_c = KIND_ABORT;
						phase_d = PH_RESYNC;
						acc_d = '0;
						seen_d = 1'b0;
					end else begin
						kind_c = KIND_FRAME;
						acc_d = next_len[LEN_W-1:0];
						seen_d = 1'b1;
					end
				end else if (pop_item.is_soh) begin
					if (!seen_q || acc_q == '0) begin
						kind_c = KIND_ABORT;
						phase_d = PH_HEADER;
						acc_d = '0;
						seen_d = 1'b0;
					end else begin
						kind_c = KIND_FRAME;
						rem_d = acc_q;
						phase_d = PH_BODY;
					end
				end else begin
					kind_c = KIND_ABORT;
					phase_d = PH_RESYNC;
					acc_d = '0;
					seen_d = 1'b0;
				end
			end
			PH_BODY: begin
				if (rem_dec == '0) begin
					kind_c = KIND_END;
					blen_c = acc_q;
					phase_d = PH_HEADER;
					acc_d = '0;
					rem_d = '0;
					seen_d = 1'b0;
				end else begin
					kind_c = KIND_FRAME;
					rem_d = rem_dec;
				end
			end
			PH_RESYNC: begin
				kind_c = KIND_DISCARD;
				if (pop_item.is_soh) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				pos_d = '0;
				acc_d = '0;
				rem_d = '0;
				seen_d = 1'b0;
			end
		endcase
	end

	// Framing state and the length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			seen_q <= 1'b0;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				pos_q <= pos_d;
				acc_q <= acc_d;
				rem_q <= rem_d;
				seen_q <= seen_d;
			end
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (pop_ready) begin
			m_axis_tvalid <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= pop_item.data;
			kind_q <= kind_c;
			blen_q <= blen_c;
		end
	end

	assign m_axis_tdata = {4'b0000, blen_q, byte_q};
	assign m_axis_tuser = kind_q;

endmodule
`default_nettype wire

[src/fix_message_deframer_top.sv]
// Channel     Dir  Beat contents
// s_axis      in   tdata[7:0] data_byte
// m_axis      out  tdata[7:0] out_byte, tdata[27:8] body_length; tuser[1:0] byte_kind
// cfg_wr      in   cfg_wr_data[19:0] max_body_length, written when cfg_wr_en is high
//
// One byte per cycle sustained while m_axis is not stalled; the framing
// state machine in the back end handles one byte in each such cycle. A byte
// accepted on s_axis passes the front register, a queue entry and the output
// register before it is presented on m_axis. Reset is asynchronous and active
// low and restarts header matching. A stall at the output fills the two-entry
// queue and then the front register before input ready drops.
`default_nettype none
module fix_message_deframer_top
	import fmd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [19:0] cfg_wr_data,   // max_body_length
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [7:0] out_byte, [27:8] body_length
	output logic [1:0]       m_axis_tuser   // [1:0] byte_kind
);

	logic   push_valid;
	logic   push_ready;
	class_t push_item;
	logic   pop_valid;
	logic   pop_ready;
	class_t pop_item;

	// Front end: accept and classify bytes.
	fmd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	// Queue between the front and back ends.
	fmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: framing state machine and output register.
	fmd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire
